@@ rtl/core/cofs_pkg.sv @@
// Types and constants shared by the operand fetch sequencer.
// No dependencies; used by cofs_step and cpu_operand_fetch_sequencer.
package cofs_pkg;

  localparam logic [15:0] HIGH_PAGE = 16'hFF00;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_DATA  = 1'b1
  } kind_t;

  typedef enum logic {
    OUT_REQUEST = 1'b0,
    OUT_DONE    = 1'b1
  } out_kind_t;

  typedef enum logic [4:0] {
    M_IMP    = 5'd0,
    M_R_D16  = 5'd1,
    M_R_R    = 5'd2,
    M_MR_R   = 5'd3,
    M_R      = 5'd4,
    M_R_D8   = 5'd5,
    M_R_MR   = 5'd6,
    M_R_HLI  = 5'd7,
    M_R_HLD  = 5'd8,
    M_HLI_R  = 5'd9,
    M_HLD_R  = 5'd10,
    M_R_A8   = 5'd11,
    M_A8_R   = 5'd12,
    M_HL_SPR = 5'd13,
    M_D16    = 5'd14,
    M_D8     = 5'd15,
    M_D16_R  = 5'd16,
    M_MR_D8  = 5'd17,
    M_MR     = 5'd18,
    M_A16_R  = 5'd19,
    M_R_A16  = 5'd20
  } mode_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_READ1 = 2'd1,
    PH_READ2 = 2'd2,
    PH_READ3 = 2'd3
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [4:0]  addressing_mode;
    logic        first_is_c;
    logic        second_is_c;
    logic [15:0] first_value;
    logic [15:0] second_value;
    logic [15:0] hl_value;
    logic [15:0] pc_value;
    logic [7:0]  read_byte;
  } item_t;

  typedef struct packed {
    logic [4:0]  held_mode;
    phase_t      phase;
    logic [15:0] running_pc;
    logic [7:0]  low_byte;
    logic [15:0] target_address;
    logic        target_is_memory;
    logic [15:0] held_operand;
    logic [15:0] pending_hl;
    logic        pending_hl_write;
  } state_t;

  typedef struct packed {
    logic        out_kind;
    logic [15:0] bus_address;
    logic [15:0] operand;
    logic        dest_in_memory;
    logic [15:0] memory_target;
    logic [15:0] next_pc;
    logic [15:0] next_hl;
    logic        hl_updated;
  } result_t;

endpackage

@@ rtl/core/cofs_step.sv @@
// Combinational step of the operand fetch sequencer: one item against the
// current state gives the next state and at most one result.
// Depends on cofs_pkg.
module cofs_step (
  input  cofs_pkg::state_t  cur,
  input  cofs_pkg::item_t   item,
  output cofs_pkg::state_t  nxt,
  output cofs_pkg::result_t res,
  output logic              res_valid
);

  logic                 do_req;
  logic [15:0]          req_addr;
  cofs_pkg::phase_t     req_phase;
  logic [15:0]          word;

  assign word = {item.read_byte, cur.low_byte};

  always_comb begin
    nxt       = cur;
    res_valid = 1'b1;
    do_req    = 1'b0;
    req_addr  = '0;
    req_phase = cofs_pkg::PH_READ1;

    if (item.kind == cofs_pkg::KIND_START) begin
      nxt.held_mode        = item.addressing_mode;
      nxt.running_pc       = item.pc_value;
      nxt.pending_hl       = item.hl_value;
      nxt.pending_hl_write = 1'b0;
      nxt.target_is_memory = 1'b0;
      nxt.target_address   = '0;
      unique case (cofs_pkg::mode_t'(item.addressing_mode))
        cofs_pkg::M_R_D16, cofs_pkg::M_D16, cofs_pkg::M_D16_R, cofs_pkg::M_R_A16,
        cofs_pkg::M_R_D8, cofs_pkg::M_HL_SPR, cofs_pkg::M_D8, cofs_pkg::M_R_A8: begin
          do_req         = 1'b1;
          req_addr       = item.pc_value;
          nxt.running_pc = item.pc_value + 16'd1;
        end
        cofs_pkg::M_A16_R, cofs_pkg::M_A8_R: begin
          nxt.target_is_memory = 1'b1;
          nxt.held_operand     = item.second_value;
          do_req               = 1'b1;
          req_addr             = item.pc_value;
          nxt.running_pc       = item.pc_value + 16'd1;
        end
        cofs_pkg::M_MR_D8: begin
          nxt.target_is_memory = 1'b1;
          nxt.target_address   = item.first_value;
          do_req               = 1'b1;
          req_addr             = item.pc_value;
          nxt.running_pc       = item.pc_value + 16'd1;
        end
        cofs_pkg::M_R_R: begin
          nxt.held_operand = item.second_value;
        end
        cofs_pkg::M_MR_R: begin
          nxt.target_is_memory = 1'b1;
          nxt.target_address   = item.first_is_c ?
                                 (item.first_value | cofs_pkg::HIGH_PAGE) : item.first_value;
          nxt.held_operand     = item.second_value;
        end
        cofs_pkg::M_R_MR: begin
          do_req   = 1'b1;
          req_addr = item.second_is_c ?
                     (item.second_value | cofs_pkg::HIGH_PAGE) : item.second_value;
        end
        cofs_pkg::M_R_HLI, cofs_pkg::M_R_HLD: begin
          nxt.pending_hl       = (item.addressing_mode == cofs_pkg::M_R_HLI) ?
                                 item.hl_value + 16'd1 : item.hl_value - 16'd1;
          nxt.pending_hl_write = 1'b1;
          do_req               = 1'b1;
          req_addr             = item.hl_value;
        end
        cofs_pkg::M_HLI_R, cofs_pkg::M_HLD_R: begin
          nxt.target_is_memory = 1'b1;
          nxt.target_address   = item.hl_value;
          nxt.held_operand     = item.second_value;
          nxt.pending_hl       = (item.addressing_mode == cofs_pkg::M_HLI_R) ?
                                 item.hl_value + 16'd1 : item.hl_value - 16'd1;
          nxt.pending_hl_write = 1'b1;
        end
        cofs_pkg::M_MR: begin
          nxt.target_is_memory = 1'b1;
          nxt.target_address   = item.first_value;
          do_req               = 1'b1;
          req_addr             = item.first_value;
        end
        default: begin
          // IMP, R and undefined codes: complete with the held operand
        end
      endcase
    end else begin
      unique case (cur.phase)
        cofs_pkg::PH_IDLE: begin
          res_valid = 1'b0;  // stray read data, dropped
        end
        cofs_pkg::PH_READ1: begin
          case (cofs_pkg::mode_t'(cur.held_mode))
            cofs_pkg::M_R_D16, cofs_pkg::M_D16, cofs_pkg::M_D16_R,
            cofs_pkg::M_A16_R, cofs_pkg::M_R_A16: begin
              nxt.low_byte   = item.read_byte;
              do_req         = 1'b1;
              req_addr       = cur.running_pc;
              req_phase      = cofs_pkg::PH_READ2;
              nxt.running_pc = cur.running_pc + 16'd1;
            end
            cofs_pkg::M_R_A8: begin
              do_req    = 1'b1;
              req_addr  = {8'hFF, item.read_byte};
              req_phase = cofs_pkg::PH_READ2;
            end
            cofs_pkg::M_A8_R: begin
              nxt.target_address = {8'hFF, item.read_byte};
            end
            default: begin
              nxt.held_operand = {8'h00, item.read_byte};
            end
          endcase
        end
        cofs_pkg::PH_READ2: begin
          case (cofs_pkg::mode_t'(cur.held_mode))
            cofs_pkg::M_A16_R: nxt.target_address = word;
            cofs_pkg::M_R_A16: begin
              do_req    = 1'b1;
              req_addr  = word;
              req_phase = cofs_pkg::PH_READ3;
            end
            cofs_pkg::M_R_A8: nxt.held_operand = {8'h00, item.read_byte};
            default:          nxt.held_operand = word;
          endcase
        end
        default: begin
          nxt.held_operand = {8'h00, item.read_byte};
        end
      endcase
    end

    if (do_req) begin
      nxt.phase       = req_phase;
      res             = '0;
      res.out_kind    = cofs_pkg::OUT_REQUEST;
      res.bus_address = req_addr;
    end else begin
      nxt.phase          = cofs_pkg::PH_IDLE;
      res.out_kind       = cofs_pkg::OUT_DONE;
      res.bus_address    = '0;
      res.operand        = nxt.held_operand;
      res.dest_in_memory = nxt.target_is_memory;
      res.memory_target  = nxt.target_is_memory ? nxt.target_address : 16'd0;
      res.next_pc        = nxt.running_pc;
      res.next_hl        = nxt.pending_hl;
      res.hl_updated     = nxt.pending_hl_write;
    end

    // data while idle leaves everything as it was
    if (!res_valid) begin
      nxt = cur;
      res = '0;
    end
  end

endmodule

@@ rtl/core/cpu_operand_fetch_sequencer.sv @@
// Operand fetch sequencer for an 8-bit CPU with 21 addressing modes.
//
// Input channel (in_valid / in_stall): a start item (kind 0) carries the
// decoded mode, register values, PC and HL; a data item (kind 1) carries the
// byte the bus returned for the last request. Output channel (out_valid /
// out_stall): each start or data item gives one result, either a bus read
// request (out_kind 0, bus_address) or the completed fetch (operand, memory
// destination, next PC, next HL). Data arriving with no fetch in progress is
// dropped without a result.
// Each item passes through the input register and then the result register,
// where its result waits until it transfers.
// Throughput: one item per cycle while out_stall is low; the decode of an
// item and the state update sit in one short step between those registers.
// When out_stall is held the result register keeps its contents, the item in
// the input register waits, and in_stall rises until the result moves on.
// A dropped data item never waits on the output side.
// Reset (rst, synchronous) empties both registers and returns the fetch
// state to idle with PC, HL, operand and address holders cleared.
module cpu_operand_fetch_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [4:0]  addressing_mode,
  input  logic        first_is_c,
  input  logic        second_is_c,
  input  logic [15:0] first_value,
  input  logic [15:0] second_value,
  input  logic [15:0] hl_value,
  input  logic [15:0] pc_value,
  input  logic [7:0]  read_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [15:0] bus_address,
  output logic [15:0] operand,
  output logic        dest_in_memory,
  output logic [15:0] memory_target,
  output logic [15:0] next_pc,
  output logic [15:0] next_hl,
  output logic        hl_updated
);

  logic              in_reg_valid;
  cofs_pkg::item_t   in_reg;
  cofs_pkg::state_t  st;
  cofs_pkg::state_t  st_next;
  cofs_pkg::result_t res;
  logic              res_valid;
  cofs_pkg::result_t out_reg;
  logic              out_free;
  logic              step_go;
  logic              in_take;

  cofs_step u_step (
    .cur       (st),
    .item      (in_reg),
    .nxt       (st_next),
    .res       (res),
    .res_valid (res_valid)
  );

  assign out_free = !out_valid || !out_stall;
  assign step_go  = in_reg_valid && (!res_valid || out_free);
  assign in_stall = in_reg_valid && !step_go;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_take || step_go) begin
      in_reg_valid <= in_take;
    end
    if (in_take) begin
      in_reg <= '{kind: kind, addressing_mode: addressing_mode, first_is_c: first_is_c,
                  second_is_c: second_is_c, first_value: first_value,
                  second_value: second_value, hl_value: hl_value, pc_value: pc_value,
                  read_byte: read_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step_go) begin
      st <= st_next;
    end
  end

  // result register: loads a new result or drains once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step_go && res_valid;
    end
    if (out_free && step_go && res_valid) begin
      out_reg <= res;
    end
  end

  assign out_kind       = out_reg.out_kind;
  assign bus_address    = out_reg.bus_address;
  assign operand        = out_reg.operand;
  assign dest_in_memory = out_reg.dest_in_memory;
  assign memory_target  = out_reg.memory_target;
  assign next_pc        = out_reg.next_pc;
  assign next_hl        = out_reg.next_hl;
  assign hl_updated     = out_reg.hl_updated;

  // only the three-byte absolute read reaches the third read
  a_read3_mode: assert property (@(posedge clk) disable iff (rst)
    st.phase == cofs_pkg::PH_READ3 |-> st.held_mode == cofs_pkg::M_R_A16)
    else $error("third read phase outside R_A16");

  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    step_go && res_valid && res.out_kind == cofs_pkg::OUT_REQUEST
    |=> st.phase != cofs_pkg::PH_IDLE)
    else $error("read request issued but sequencer idle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    step_go && res_valid && res.out_kind == cofs_pkg::OUT_DONE
    |=> st.phase == cofs_pkg::PH_IDLE)
    else $error("fetch completed but sequencer not idle");

  a_drop_idle: assert property (@(posedge clk) disable iff (rst)
    step_go && !res_valid |-> st.phase == cofs_pkg::PH_IDLE &&
    in_reg.kind == cofs_pkg::KIND_DATA)
    else $error("item dropped while a fetch was running");

  a_req_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == cofs_pkg::OUT_REQUEST |-> operand == 16'd0 && !hl_updated &&
    !dest_in_memory)
    else $error("request result carries completion fields");

endmodule
